>>> src/lav_pkg.sv
// Shared types, widths and fixed-point helpers for the look-at view matrix block.
// Depends on nothing; used by lav_norm and look_at_view_matrix.
`timescale 1ns / 1ps

package lav_pkg;

  localparam int VEC_W    = 16;  // Q2.14 axis component
  localparam int POS_W    = 32;  // Q16.16 position / translation
  localparam int ND_W     = 17;  // negated direction, holds +32768
  localparam int RAW_W    = 33;  // cross product of two Q2.14 vectors
  localparam int MAG_W    = 32;  // magnitude of a cross product
  localparam int SQ_W     = 64;  // sum of squares
  localparam int ROOT_W   = 32;  // integer square root
  localparam int NUM_W    = 47;  // rounded dividend |c| * 2^14 + L/2
  localparam int QUO_W    = 16;  // quotient bits, top one always zero
  localparam int SH_W     = 5;   // normalizing shift count
  localparam int PROD_W   = 48;  // axis * position
  localparam int DOT_W    = 50;  // sum of three products
  localparam int SQRT_STG = 16;  // two root bits per stage
  localparam int DIV_STG  = 8;   // two quotient bits per stage
  localparam int NORM_LAT = 5 + SQRT_STG + 1 + DIV_STG + 1;
  localparam int NORM_TGT = 30;  // normalize until the largest magnitude has this bit set
  localparam int ROUND_SH = 14;

  localparam logic signed [POS_W-1:0] TRANS_ONE = 32'sd65536;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic signed [VEC_W-1:0]  comp_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [ND_W-1:0]   nd_t;
  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]  dot_t;

  // a*b - c*d, exact in RAW_W bits for Q2.14 operands
  function automatic raw_t cross_term(input nd_t a, input nd_t b, input nd_t c, input nd_t d);
    raw_t pa;
    raw_t pb;
    pa = raw_t'(a) * raw_t'(b);
    pb = raw_t'(c) * raw_t'(d);
    return pa - pb;
  endfunction

  // Q4.28 to Q2.14, round half away from zero, saturate
  function automatic comp_t back_of(input raw_t v);
    logic [RAW_W-1:0] mag;
    logic [RAW_W-1:0] r;
    comp_t res;
    mag = v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
    r   = (mag + RAW_W'(8192)) >> ROUND_SH;
    if (v[RAW_W-1]) begin
      res = (r > RAW_W'(32768)) ? comp_t'(-32768) : comp_t'(-r[VEC_W-1:0]);
    end else begin
      res = (r > RAW_W'(32767)) ? comp_t'(32767) : comp_t'(r[VEC_W-1:0]);
    end
    return res;
  endfunction

  // -(dot) from Q20.30 to Q16.16, round half away from zero, saturate
  function automatic pos_t trans_of(input dot_t v);
    logic [DOT_W-1:0] mag;
    logic [DOT_W-1:0] r;
    pos_t res;
    mag = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
    r   = (mag + DOT_W'(8192)) >> ROUND_SH;
    if (v[DOT_W-1]) begin
      res = (r > DOT_W'(32'h7fff_ffff)) ? pos_t'(32'h7fff_ffff) : pos_t'(r[POS_W-1:0]);
    end else begin
      res = (r > DOT_W'(33'h0_8000_0000)) ? pos_t'(32'h8000_0000)
                                          : pos_t'(-r[POS_W-1:0]);
    end
    return res;
  endfunction

endpackage

>>> src/lav_norm.sv
// Pipelined vector normalizer: magnitude, shift, root, per-lane division.
// Depends on lav_pkg. All stages advance on en_i.
`timescale 1ns / 1ps

module lav_norm import lav_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  raw_t  vec_i [3],
  output logic  valid_o,
  output logic  ok_o,
  output comp_t axis_o [3]
);

  // stage A: magnitudes and largest one
  logic             a_vld_q;
  logic [MAG_W-1:0] a_mag_q [3];
  logic             a_neg_q [3];
  logic [MAG_W-1:0] a_mx_q;
  logic [MAG_W-1:0] a_mag_d [3];
  logic [MAG_W-1:0] a_mx_d;

  always_comb begin
    a_mx_d = '0;
    for (int i = 0; i < 3; i++) begin
      a_mag_d[i] = vec_i[i][RAW_W-1] ? MAG_W'(-vec_i[i]) : MAG_W'(vec_i[i]);
      if (a_mag_d[i] > a_mx_d) a_mx_d = a_mag_d[i];
    end
  end

  // stage B: normalizing shift count
  logic             b_vld_q;
  logic [MAG_W-1:0] b_mag_q [3];
  logic             b_neg_q [3];
  logic             b_nz_q;
  logic [SH_W-1:0]  b_sh_q;
  logic [SH_W-1:0]  msb;
  logic [SH_W-1:0]  b_sh_d;

  always_comb begin
    msb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (a_mx_q[i]) msb = SH_W'(i);
    end
    b_sh_d = (msb >= SH_W'(NORM_TGT)) ? '0 : SH_W'(NORM_TGT) - msb;
  end

  // stage C: shifted magnitudes, stage D: squares
  logic             c_vld_q, d_vld_q;
  logic [MAG_W-1:0] c_mag_q [3];
  logic [MAG_W-1:0] d_mag_q [3];
  logic             c_neg_q [3];
  logic             d_neg_q [3];
  logic             c_nz_q, d_nz_q;
  logic [SQ_W-1:0]  d_sq_q [3];

  // root stages, index 0 holds the sum of squares
  logic             s_vld_q [SQRT_STG+1];
  logic [SQ_W-1:0]  s_n_q   [SQRT_STG+1];
  logic [SQ_W-1:0]  s_res_q [SQRT_STG+1];
  logic [MAG_W-1:0] s_mag_q [SQRT_STG+1][3];
  logic             s_neg_q [SQRT_STG+1][3];
  logic             s_nz_q  [SQRT_STG+1];

  // division stages, index 0 holds the rounded dividends
  logic              v_vld_q [DIV_STG+1];
  logic [NUM_W-1:0]  v_rem_q [DIV_STG+1][3];
  logic [QUO_W-1:0]  v_quo_q [DIV_STG+1][3];
  logic [ROOT_W-1:0] v_den_q [DIV_STG+1];
  logic              v_neg_q [DIV_STG+1][3];
  logic              v_nz_q  [DIV_STG+1];

  logic [ROOT_W-1:0] len;

  // front stages payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mx_q <= a_mx_d;
      b_sh_q <= b_sh_d;
      b_nz_q <= (a_mx_q != '0);
      c_nz_q <= b_nz_q;
      d_nz_q <= c_nz_q;
      s_nz_q[0]  <= d_nz_q;
      s_n_q[0]   <= d_sq_q[0] + d_sq_q[1] + d_sq_q[2];
      s_res_q[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        a_mag_q[i] <= a_mag_d[i];
        a_neg_q[i] <= vec_i[i][RAW_W-1];
        b_mag_q[i] <= a_mag_q[i];
        b_neg_q[i] <= a_neg_q[i];
        c_mag_q[i] <= b_mag_q[i] << b_sh_q;
        c_neg_q[i] <= b_neg_q[i];
        d_mag_q[i] <= c_mag_q[i];
        d_neg_q[i] <= c_neg_q[i];
        d_sq_q[i]  <= SQ_W'(c_mag_q[i]) * SQ_W'(c_mag_q[i]);
        s_mag_q[0][i] <= d_mag_q[i];
        s_neg_q[0][i] <= d_neg_q[i];
      end
    end
  end

  // square root, two bits per stage
  for (genvar k = 0; k < SQRT_STG; k++) begin : g_sqrt
    localparam int B0 = 62 - 4 * k;
    localparam int B1 = 60 - 4 * k;
    logic [SQ_W-1:0] n1, r1, n2, r2;
    always_comb begin
      if (s_n_q[k] >= s_res_q[k] + (SQ_W'(1) << B0)) begin
        n1 = s_n_q[k] - (s_res_q[k] + (SQ_W'(1) << B0));
        r1 = (s_res_q[k] >> 1) + (SQ_W'(1) << B0);
      end else begin
        n1 = s_n_q[k];
        r1 = s_res_q[k] >> 1;
      end
      if (n1 >= r1 + (SQ_W'(1) << B1)) begin
        n2 = n1 - (r1 + (SQ_W'(1) << B1));
        r2 = (r1 >> 1) + (SQ_W'(1) << B1);
      end else begin
        n2 = n1;
        r2 = r1 >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_n_q[k+1]   <= n2;
        s_res_q[k+1] <= r2;
        s_nz_q[k+1]  <= s_nz_q[k];
        for (int i = 0; i < 3; i++) begin
          s_mag_q[k+1][i] <= s_mag_q[k][i];
          s_neg_q[k+1][i] <= s_neg_q[k][i];
        end
      end
    end
  end

  // dividend |c| * 2^14 + L/2 against divisor L
  assign len = (s_res_q[SQRT_STG][ROOT_W-1:0] == '0) ? ROOT_W'(1)
                                                      : s_res_q[SQRT_STG][ROOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_den_q[0] <= len;
      v_nz_q[0]  <= s_nz_q[SQRT_STG];
      for (int i = 0; i < 3; i++) begin
        v_rem_q[0][i] <= NUM_W'({s_mag_q[SQRT_STG][i], 14'b0}) + NUM_W'(len >> 1);
        v_quo_q[0][i] <= '0;
        v_neg_q[0][i] <= s_neg_q[SQRT_STG][i];
      end
    end
  end

  // restoring division, two quotient bits per stage
  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    localparam int J0 = QUO_W - 1 - 2 * k;
    localparam int J1 = QUO_W - 2 - 2 * k;
    logic [NUM_W:0]   dsh0, dsh1;
    logic [NUM_W-1:0] rem1 [3];
    logic [NUM_W-1:0] rem2 [3];
    logic [QUO_W-1:0] quo2 [3];
    always_comb begin
      dsh0 = (NUM_W+1)'(v_den_q[k]) << J0;
      dsh1 = (NUM_W+1)'(v_den_q[k]) << J1;
      for (int i = 0; i < 3; i++) begin
        quo2[i] = v_quo_q[k][i];
        rem1[i] = v_rem_q[k][i];
        if ({1'b0, v_rem_q[k][i]} >= dsh0) begin
          rem1[i] = v_rem_q[k][i] - dsh0[NUM_W-1:0];
          quo2[i][J0] = 1'b1;
        end
        rem2[i] = rem1[i];
        if ({1'b0, rem1[i]} >= dsh1) begin
          rem2[i] = rem1[i] - dsh1[NUM_W-1:0];
          quo2[i][J1] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_den_q[k+1] <= v_den_q[k];
        v_nz_q[k+1]  <= v_nz_q[k];
        for (int i = 0; i < 3; i++) begin
          v_rem_q[k+1][i] <= rem2[i];
          v_quo_q[k+1][i] <= quo2[i];
          v_neg_q[k+1][i] <= v_neg_q[k][i];
        end
      end
    end
  end

  // output stage: apply sign, zero vector stays zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_o <= v_nz_q[DIV_STG];
      for (int i = 0; i < 3; i++) begin
        if (!v_nz_q[DIV_STG]) begin
          axis_o[i] <= '0;
        end else if (v_neg_q[DIV_STG][i]) begin
          axis_o[i] <= comp_t'(-v_quo_q[DIV_STG][i]);
        end else begin
          axis_o[i] <= comp_t'(v_quo_q[DIV_STG][i]);
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      valid_o <= 1'b0;
      for (int k = 0; k <= SQRT_STG; k++) s_vld_q[k] <= 1'b0;
      for (int k = 0; k <= DIV_STG; k++) v_vld_q[k] <= 1'b0;
    end else if (en_i) begin
      a_vld_q    <= valid_i;
      b_vld_q    <= a_vld_q;
      c_vld_q    <= b_vld_q;
      d_vld_q    <= c_vld_q;
      s_vld_q[0] <= d_vld_q;
      for (int k = 0; k < SQRT_STG; k++) s_vld_q[k+1] <= s_vld_q[k];
      v_vld_q[0] <= s_vld_q[SQRT_STG];
      for (int k = 0; k < DIV_STG; k++) v_vld_q[k+1] <= v_vld_q[k];
      valid_o    <= v_vld_q[DIV_STG];
    end
  end

endmodule

>>> src/look_at_view_matrix.sv
// An item passes stages 1 to 7 and both normalizers into the serializer; rows 1..3 follow row 0.
// Throughput: set by the result port, four rows per item, one per cycle with out_ready_i high;
// the pipeline itself takes an item per cycle and stalls as a whole on back-pressure.
// Reset: rst_ni clears all valid bits and the row counter; payload registers are not reset.
// Depends on lav_pkg and lav_norm (two instances, one per normalized axis).
`timescale 1ns / 1ps

module look_at_view_matrix import lav_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pos_t        pos_x_i,
  input  pos_t        pos_y_i,
  input  pos_t        pos_z_i,
  input  comp_t       dir_x_i,
  input  comp_t       dir_y_i,
  input  comp_t       dir_z_i,
  input  comp_t       up_x_i,
  input  comp_t       up_y_i,
  input  comp_t       up_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  row_index_o,
  output comp_t       col0_o,
  output comp_t       col1_o,
  output comp_t       col2_o,
  output pos_t        col3_o,
  output logic        degenerate_o,
  output logic        last_row_o
);

  logic adv;    // whole pipeline moves
  logic take;   // serializer loads a finished matrix

  // stage 1: input registers
  logic  v1_q;
  pos_t  pos1_q [3];
  nd_t   nd1_q  [3];
  comp_t up1_q  [3];

  // stage 2: right = up x -dir, raw
  logic  v2_q;
  raw_t  raw1_q [3];
  pos_t  pos2_q [3];
  nd_t   nd2_q  [3];

  // first normalizer and its side line
  logic  n1_vld, ok1;
  comp_t ax0 [3];
  pos_t  dl1_pos_q [NORM_LAT][3];
  nd_t   dl1_nd_q  [NORM_LAT][3];

  // stage 3: upward = -dir x right, raw
  logic  v3_q, ok1_3_q;
  raw_t  raw2_q [3];
  pos_t  pos3_q [3];
  comp_t ax0_3_q [3];

  // second normalizer and its side line
  logic  n2_vld, ok2;
  comp_t ax1 [3];
  pos_t  dl2_pos_q [NORM_LAT][3];
  comp_t dl2_ax0_q [NORM_LAT][3];
  logic  dl2_ok1_q [NORM_LAT];

  // stage 4: back raw, stage 5: back rounded, stage 6: products, stage 7: translations
  logic  v4_q, v5_q, v6_q, v7_q;
  logic  dg4_q, dg5_q, dg6_q, dg7_q;
  raw_t  raw3_q [3];
  pos_t  pos4_q [3];
  pos_t  pos5_q [3];
  comp_t ax4_q [2][3];
  comp_t ax5_q [3][3];
  comp_t ax6_q [3][3];
  comp_t ax7_q [3][3];
  prod_t prod6_q [3][3];
  pos_t  tr7_q [3];

  // serializer
  logic       out_vld_q;
  logic [1:0] row_q;
  comp_t      sax_q [3][3];
  pos_t       str_q [3];
  logic       sdg_q;

  assign take       = v7_q && (!out_vld_q || (out_ready_i && row_q == ROW_LAST));
  assign adv        = !v7_q || take;
  assign in_ready_o = adv;

  // stages 1 and 2
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos1_q[0] <= pos_x_i;
      pos1_q[1] <= pos_y_i;
      pos1_q[2] <= pos_z_i;
      nd1_q[0]  <= -nd_t'(dir_x_i);
      nd1_q[1]  <= -nd_t'(dir_y_i);
      nd1_q[2]  <= -nd_t'(dir_z_i);
      up1_q[0]  <= up_x_i;
      up1_q[1]  <= up_y_i;
      up1_q[2]  <= up_z_i;
      raw1_q[0] <= cross_term(nd_t'(up1_q[1]), nd1_q[2], nd_t'(up1_q[2]), nd1_q[1]);
      raw1_q[1] <= cross_term(nd_t'(up1_q[2]), nd1_q[0], nd_t'(up1_q[0]), nd1_q[2]);
      raw1_q[2] <= cross_term(nd_t'(up1_q[0]), nd1_q[1], nd_t'(up1_q[1]), nd1_q[0]);
      for (int i = 0; i < 3; i++) begin
        pos2_q[i] <= pos1_q[i];
        nd2_q[i]  <= nd1_q[i];
      end
    end
  end

  lav_norm u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .vec_i   (raw1_q),
    .valid_o (n1_vld),
    .ok_o    (ok1),
    .axis_o  (ax0)
  );

  // side line across the first normalizer, then stage 3
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dl1_pos_q[0][i] <= pos2_q[i];
        dl1_nd_q[0][i]  <= nd2_q[i];
        for (int k = 1; k < NORM_LAT; k++) begin
          dl1_pos_q[k][i] <= dl1_pos_q[k-1][i];
          dl1_nd_q[k][i]  <= dl1_nd_q[k-1][i];
        end
        pos3_q[i]  <= dl1_pos_q[NORM_LAT-1][i];
        ax0_3_q[i] <= ax0[i];
      end
      ok1_3_q   <= ok1;
      raw2_q[0] <= cross_term(dl1_nd_q[NORM_LAT-1][1], nd_t'(ax0[2]),
                              dl1_nd_q[NORM_LAT-1][2], nd_t'(ax0[1]));
      raw2_q[1] <= cross_term(dl1_nd_q[NORM_LAT-1][2], nd_t'(ax0[0]),
                              dl1_nd_q[NORM_LAT-1][0], nd_t'(ax0[2]));
      raw2_q[2] <= cross_term(dl1_nd_q[NORM_LAT-1][0], nd_t'(ax0[1]),
                              dl1_nd_q[NORM_LAT-1][1], nd_t'(ax0[0]));
    end
  end

  lav_norm u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .vec_i   (raw2_q),
    .valid_o (n2_vld),
    .ok_o    (ok2),
    .axis_o  (ax1)
  );

  // side line across the second normalizer, then stages 4 to 7
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl2_ok1_q[0] <= ok1_3_q;
      for (int k = 1; k < NORM_LAT; k++) dl2_ok1_q[k] <= dl2_ok1_q[k-1];
      for (int i = 0; i < 3; i++) begin
        dl2_pos_q[0][i] <= pos3_q[i];
        dl2_ax0_q[0][i] <= ax0_3_q[i];
        for (int k = 1; k < NORM_LAT; k++) begin
          dl2_pos_q[k][i] <= dl2_pos_q[k-1][i];
          dl2_ax0_q[k][i] <= dl2_ax0_q[k-1][i];
        end
        pos4_q[i]   <= dl2_pos_q[NORM_LAT-1][i];
        ax4_q[0][i] <= dl2_ax0_q[NORM_LAT-1][i];
        ax4_q[1][i] <= ax1[i];
      end
      dg4_q <= !(dl2_ok1_q[NORM_LAT-1] && ok2);
      raw3_q[0] <= cross_term(nd_t'(dl2_ax0_q[NORM_LAT-1][1]), nd_t'(ax1[2]),
                              nd_t'(dl2_ax0_q[NORM_LAT-1][2]), nd_t'(ax1[1]));
      raw3_q[1] <= cross_term(nd_t'(dl2_ax0_q[NORM_LAT-1][2]), nd_t'(ax1[0]),
                              nd_t'(dl2_ax0_q[NORM_LAT-1][0]), nd_t'(ax1[2]));
      raw3_q[2] <= cross_term(nd_t'(dl2_ax0_q[NORM_LAT-1][0]), nd_t'(ax1[1]),
                              nd_t'(dl2_ax0_q[NORM_LAT-1][1]), nd_t'(ax1[0]));

      dg5_q <= dg4_q;
      dg6_q <= dg5_q;
      dg7_q <= dg6_q;
      for (int i = 0; i < 3; i++) begin
        pos5_q[i]   <= pos4_q[i];
        ax5_q[0][i] <= ax4_q[0][i];
        ax5_q[1][i] <= ax4_q[1][i];
        ax5_q[2][i] <= back_of(raw3_q[i]);
      end
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          ax6_q[r][i]   <= ax5_q[r][i];
          prod6_q[r][i] <= prod_t'(ax5_q[r][i]) * prod_t'(pos5_q[i]);
          ax7_q[r][i]   <= ax6_q[r][i];
        end
        tr7_q[r] <= trans_of(dot_t'(prod6_q[r][0]) + dot_t'(prod6_q[r][1])
                             + dot_t'(prod6_q[r][2]));
      end
    end
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= n1_vld;
      v4_q <= n2_vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // serializer payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      sdg_q <= dg7_q;
      for (int r = 0; r < 3; r++) begin
        str_q[r] <= tr7_q[r];
        for (int i = 0; i < 3; i++) sax_q[r][i] <= ax7_q[r][i];
      end
    end
  end

  // serializer control: four rows per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      row_q     <= '0;
    end else if (take) begin
      out_vld_q <= 1'b1;
      row_q     <= '0;
    end else if (out_vld_q && out_ready_i) begin
      if (row_q == ROW_LAST) begin
        out_vld_q <= 1'b0;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  // row select
  always_comb begin
    unique case (row_q)
      2'd0: begin
        col0_o = sax_q[0][0]; col1_o = sax_q[0][1]; col2_o = sax_q[0][2]; col3_o = str_q[0];
      end
      2'd1: begin
        col0_o = sax_q[1][0]; col1_o = sax_q[1][1]; col2_o = sax_q[1][2]; col3_o = str_q[1];
      end
      2'd2: begin
        col0_o = sax_q[2][0]; col1_o = sax_q[2][1]; col2_o = sax_q[2][2]; col3_o = str_q[2];
      end
      default: begin
        col0_o = '0; col1_o = '0; col2_o = '0; col3_o = TRANS_ONE;
      end
    endcase
  end

  assign out_valid_o  = out_vld_q;
  assign row_index_o  = row_q;
  assign degenerate_o = sdg_q;
  assign last_row_o   = (row_q == ROW_LAST);

`ifndef SYNTHESIS
  // rows advance one at a time within an item
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_ready_i && row_q != ROW_LAST && !take
      |=> out_vld_q && row_q == $past(row_q) + 2'd1)
    else $error("row counter skipped");

  // a newly loaded matrix starts at row 0
  a_load_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_vld_q && row_q == 2'd0)
    else $error("matrix load did not restart rows");

  // a stalled pipeline keeps its oldest item
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> v7_q && $stable(tr7_q[0]) && $stable(dg7_q))
    else $error("stalled item changed");

  // degenerate flag stays the same over all rows of one matrix
  a_degen_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_ready_i && row_q != ROW_LAST |=> $stable(sdg_q))
    else $error("degenerate flag changed within a matrix");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for look_at_view_matrix: drives camera items, predicts the
// four view-matrix rows per item and checks every output row. Depends on lav_pkg.
`timescale 1ns / 1ps

module testbench;
  import lav_pkg::*;

  localparam int N_RAND    = 400;
  localparam int CYC_LIMIT = 400000;
  localparam int DRAIN     = 100;

  typedef struct {
    pos_t  px, py, pz;
    comp_t dx, dy, dz;
    comp_t ux, uy, uz;
  } cam_t;

  typedef struct {
    logic [1:0] idx;
    comp_t      c0, c1, c2;
    pos_t       c3;
    logic       degen;
    logic       last;
  } row_t;

  // directed rows; has_exp marks rows whose row 0 is typed in
  typedef struct {
    cam_t cam;
    bit   has_exp;
    row_t exp0;
  } dir_row_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  pos_t  pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  comp_t dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  comp_t up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  logic [1:0] row_index_o;
  comp_t col0_o, col1_o, col2_o;
  pos_t  col3_o;
  logic  degenerate_o, last_row_o;

  row_t  rows_due[$];
  int    n_err = 0;
  int    cycles = 0;
  bit    sending_done = 1'b0;
  bit    hold_long = 1'b0;

  always #5 clk_i = ~clk_i;

  look_at_view_matrix uut (.*);

  // ---------------- predictor ----------------
  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_axis(input longint r[3], output longint q[3]);
    longint unsigned m[3], mx, l2, len, v;
    mx = 0;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(r[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      q = '{0, 0, 0};
      return 1'b0;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) l2 += m[i] * m[i];
    len = int_sqrt(l2);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      v = (m[i] * 64'd16384 + len / 2) / len;
      if (v > 32767) v = 32767;
      q[i] = r[i] < 0 ? -longint'(v) : longint'(v);
    end
    return 1'b1;
  endfunction

  function automatic longint rnd14(longint v);
    longint unsigned r;
    r = (mag64(v) + 8192) >> 14;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  task automatic predict_view_rows(input cam_t c);
    longint p[3], nd[3], u[3], raw[3], ax[3][3], t, dot;
    bit ok1, ok2;
    row_t r;
    p  = '{c.px, c.py, c.pz};
    nd = '{-longint'(c.dx), -longint'(c.dy), -longint'(c.dz)};
    u  = '{c.ux, c.uy, c.uz};
    cross3(u, nd, raw);
    ok1 = unit_axis(raw, ax[0]);
    cross3(nd, ax[0], raw);
    ok2 = unit_axis(raw, ax[1]);
    cross3(ax[0], ax[1], raw);
    for (int i = 0; i < 3; i++) ax[2][i] = clip(rnd14(raw[i]), -32768, 32767);
    for (int k = 0; k < 4; k++) begin
      r.idx = k[1:0];
      r.degen = !(ok1 && ok2);
      r.last = (k == 3);
      if (k < 3) begin
        dot = 0;
        for (int i = 0; i < 3; i++) dot += ax[k][i] * p[i];
        t = clip(-rnd14(dot), -64'sd2147483648, 64'sd2147483647);
        r.c0 = comp_t'(ax[k][0]);
        r.c1 = comp_t'(ax[k][1]);
        r.c2 = comp_t'(ax[k][2]);
      end else begin
        r.c0 = '0;
        r.c1 = '0;
        r.c2 = '0;
        t = 65536;
      end
      r.c3 = pos_t'(t);
      rows_due.push_back(r);
    end
  endtask

  // ---------------- stimulus ----------------
  function automatic cam_t mk(longint px, longint py, longint pz, longint dx, longint dy,
                              longint dz, longint ux, longint uy, longint uz);
    cam_t c;
    c.px = pos_t'(px); c.py = pos_t'(py); c.pz = pos_t'(pz);
    c.dx = comp_t'(dx); c.dy = comp_t'(dy); c.dz = comp_t'(dz);
    c.ux = comp_t'(ux); c.uy = comp_t'(uy); c.uz = comp_t'(uz);
    return c;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0:       return comp_t'($urandom_range(0, 1) ? 32767 : -32768);
      1:       return comp_t'($urandom_range(0, 7) - 4);
      2:       return comp_t'($urandom_range(0, 1) ? 16384 : -16384);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic pos_t rand_pos();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1:       return pos_t'($urandom_range(0, 1023) - 512) <<< 16;
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic cam_t rand_cam();
    cam_t c;
    c.px = rand_pos(); c.py = rand_pos(); c.pz = rand_pos();
    c.dx = rand_comp(); c.dy = rand_comp(); c.dz = rand_comp();
    case ($urandom_range(0, 9))
      0: begin  // parallel up, degenerate
        c.ux = c.dx; c.uy = c.dy; c.uz = c.dz;
      end
      1: begin  // zero up
        c.ux = '0; c.uy = '0; c.uz = '0;
      end
      default: begin
        c.ux = rand_comp(); c.uy = rand_comp(); c.uz = rand_comp();
      end
    endcase
    return c;
  endfunction

  // valid drops only when a gap follows, so back-to-back items keep it high
  task automatic send_item(input cam_t c);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= c.px; pos_y_i <= c.py; pos_z_i <= c.pz;
    dir_x_i <= c.dx; dir_y_i <= c.dy; dir_z_i <= c.dz;
    up_x_i <= c.ux; up_y_i <= c.uy; up_z_i <= c.uz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_view_rows(c);
  endtask

  dir_row_t plan[$];
  row_t     zero_row0;

  initial begin
    zero_row0 = '{idx: 2'd0, c0: '0, c1: '0, c2: '0, c3: '0, degen: 1'b1, last: 1'b0};
    // standard camera looking down -z, up +y: right = +x
    plan.push_back('{mk(0, 0, 0, 0, 0, -16384, 0, 16384, 0), 1'b1,
                    '{2'd0, 16384, 0, 0, 0, 1'b0, 1'b0}});
    // all zero and parallel vectors
    plan.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_row0});
    plan.push_back('{mk(65536, 0, 0, 16384, 0, 0, 16384, 0, 0), 1'b1, zero_row0});
    plan.push_back('{mk(1, 2, 3, 0, 0, 0, 0, 16384, 0), 1'b1, zero_row0});
    plan.push_back('{mk(0, 0, 0, 0, 16384, 0, 0, 0, 0), 1'b1, zero_row0});
    // most negative and largest components
    plan.push_back('{mk(0, 0, 0, -32768, -32768, -32768, 32767, -32768, 0), 1'b0, zero_row0});
    plan.push_back('{mk(0, 0, 0, -32768, 0, 0, 0, -32768, 0), 1'b0, zero_row0});
    plan.push_back('{mk(0, 0, 0, 32767, 32767, 32767, -32768, 32767, -32768), 1'b0, zero_row0});
    // saturating translations
    plan.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -16384, -16384, -16384,
                        0, 16384, 0), 1'b0, zero_row0});
    plan.push_back('{mk(-2147483648, -2147483648, -2147483648, 32767, 32767, 32767,
                        -32768, 32767, 0), 1'b0, zero_row0});
    plan.push_back('{mk(-2147483648, 32'h7fffffff, -2147483648, 0, 0, -32768,
                        0, 32767, 0), 1'b0, zero_row0});
    // tiny vectors, large shift in normalize
    plan.push_back('{mk(12345, -678, 9, 1, 0, 0, 0, 1, 0), 1'b0, zero_row0});
    plan.push_back('{mk(-1, 1, -1, -1, -1, 1, 1, -1, -1), 1'b0, zero_row0});
    plan.push_back('{mk(1 << 20, 0, -(1 << 20), 3, -5, 7, -2, 9, 1), 1'b0, zero_row0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) begin
      if (plan[i].has_exp) begin
        predict_view_rows(plan[i].cam);
        // typed row 0 must agree with the predictor as well
        if (rows_due[$-3] != plan[i].exp0) begin
          $error("directed row %0d: typed row 0 disagrees with prediction", i);
          n_err++;
        end
        void'(rows_due.pop_back()); void'(rows_due.pop_back());
        void'(rows_due.pop_back()); void'(rows_due.pop_back());
      end
      send_item(plan[i].cam);
    end
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 60) hold_long = 1'b1;
      send_item(rand_cam());
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  // ---------------- receiver ----------------
  initial begin
    int stall;
    while (1) begin
      if (hold_long) begin
        // long hold-off so the pipeline fills and input backs up
        out_ready_i <= 1'b0;
        hold_long = 1'b0;
        repeat (300) @(posedge clk_i);
      end
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk_i) begin
    row_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rows_due.size() == 0) begin
        $error("unexpected row, index %0d", row_index_o);
        n_err++;
      end else begin
        e = rows_due.pop_front();
        if (row_index_o !== e.idx) begin
          $error("row_index exp %0d got %0d", e.idx, row_index_o); n_err++;
        end
        if (col0_o !== e.c0) begin
          $error("col0 exp %0d got %0d", e.c0, col0_o); n_err++;
        end
        if (col1_o !== e.c1) begin
          $error("col1 exp %0d got %0d", e.c1, col1_o); n_err++;
        end
        if (col2_o !== e.c2) begin
          $error("col2 exp %0d got %0d", e.c2, col2_o); n_err++;
        end
        if (col3_o !== e.c3) begin
          $error("col3 exp %0d got %0d", e.c3, col3_o); n_err++;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, degenerate_o); n_err++;
        end
        if (last_row_o !== e.last) begin
          $error("last_row exp %0d got %0d", e.last, last_row_o); n_err++;
        end
      end
    end
  end

  // ---------------- end of run ----------------
  initial begin
    while (!(sending_done && rows_due.size() == 0) && cycles < CYC_LIMIT) @(posedge clk_i);
    if (cycles < CYC_LIMIT) repeat (DRAIN) @(posedge clk_i);
    if (cycles >= CYC_LIMIT) $display("look_at_view_matrix: mismatch");
    else if (n_err == 0 && rows_due.size() == 0) $display("look_at_view_matrix: match");
    else $display("look_at_view_matrix: mismatch");
    $finish;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

endmodule
